### src/lfu_pkg.sv
// Package with shared types and constants for the LFU cache policy block.
`default_nettype none

package lfu_pkg;

    // Default number of entries in the store.
    localparam int unsigned LFU_ENTRIES = 16;

    // Field widths.
    localparam int unsigned CAP_W   = 5;
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned USES_W  = 32;
    localparam int unsigned STAMP_W = 64;

    // Capacity after reset.
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    // Value returned by a get that misses.
    localparam logic signed [DATA_W-1:0] MISS_VALUE = -DATA_W'(1);

    // Use count given to a freshly inserted entry.
    localparam logic [USES_W-1:0] USES_INIT = USES_W'(1);

    // Request modes.
    localparam logic MODE_GET = 1'b0;
    localparam logic MODE_PUT = 1'b1;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT
    } t_state;

    // Request payload.
    typedef struct packed {
        logic                     mode;
        logic signed [DATA_W-1:0] key;
        logic signed [DATA_W-1:0] value;
    } t_req;

    // Response payload.
    typedef struct packed {
        logic                     hit;
        logic signed [DATA_W-1:0] read_value;
        logic                     evicted;
        logic signed [DATA_W-1:0] evicted_key;
    } t_rsp;

    // Configuration payload.
    typedef logic [CAP_W-1:0] t_cfg;

    // One stored entry.
    typedef struct packed {
        logic [DATA_W-1:0]  key;
        logic [DATA_W-1:0]  value;
        logic [USES_W-1:0]  uses;
        logic [STAMP_W-1:0] stamp;
    } t_entry;

endpackage

`default_nettype wire

### src/lfu_stream_if.sv
// Valid/ready channel interface used for requests, responses and configuration.
`default_nettype none

interface lfu_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### src/lfu_store.sv
// Entry memory of the LFU cache: one write port and one registered read port.
`default_nettype none

module lfu_store #(
    parameter int unsigned ENTRIES = lfu_pkg::LFU_ENTRIES,
    parameter int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  wire              i_clk,
    input  wire              i_we,
    input  wire  [IDX_W-1:0] i_waddr,
    input  lfu_pkg::t_entry  i_wdata,
    input  wire  [IDX_W-1:0] i_raddr,
    output lfu_pkg::t_entry  o_rdata
);

    lfu_pkg::t_entry r_mem [ENTRIES];
    lfu_pkg::t_entry r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### src/lfu_cache_policy.sv
// Top level of the LFU cache policy block with LRU tie-break.
//
// Usage: requests arrive on i_req (mode, key, value), one response per request
// leaves on o_rsp (hit, read_value, evicted, evicted_key), and the capacity
// register is written through i_cfg, which is always ready.
// Each request is handled by a sequencer that walks every entry through the
// single read port of the entry memory, one entry per cycle, while one shared
// compare path finds the key match, the free slot and the victim (fewest uses,
// then oldest stamp). After the walk, the commit state writes any touched or
// inserted entry to the memory and loads the response register.
// A new request is taken only in the idle state, once the previous one has
// committed, so the pace is set by the one-entry-per-cycle walk over the
// memory read port.
// The response register lets the next request be taken while a response
// waits; if the receiver stalls, the next commit waits until the held
// response is transferred.
// Reset clears all valid bits, the access clock and sets the capacity to 16;
// no clearing pass is needed, so requests are taken right after reset.
`default_nettype none

module lfu_cache_policy #(
    parameter int unsigned ENTRIES = lfu_pkg::LFU_ENTRIES
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    lfu_stream_if.sink   i_req,
    lfu_stream_if.source o_rsp,
    lfu_stream_if.sink   i_cfg
);

    localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
    localparam int unsigned CMP_W = (CNT_W > lfu_pkg::CAP_W) ? CNT_W : lfu_pkg::CAP_W;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
    localparam logic [CMP_W-1:0] MAX_CAP  = CMP_W'(ENTRIES);

    // Sequencer and capacity.
    lfu_pkg::t_state r_state, n_state;
    logic [lfu_pkg::CAP_W-1:0] r_capacity;

    // Request held during the walk.
    lfu_pkg::t_req r_req;

    // Walk pipeline.
    logic [IDX_W-1:0] r_addr;
    logic [IDX_W-1:0] r_data_idx;
    logic             r_pend;

    // Store state.
    logic [ENTRIES-1:0]         r_valid;
    logic [lfu_pkg::STAMP_W-1:0] r_clock;

    // Walk results.
    logic [CNT_W-1:0]            r_count;
    logic                        r_hit;
    logic [IDX_W-1:0]            r_found_idx;
    logic [lfu_pkg::DATA_W-1:0]  r_found_value;
    logic [lfu_pkg::USES_W-1:0]  r_found_uses;
    logic                        r_have_free;
    logic [IDX_W-1:0]            r_free_idx;
    logic                        r_have_vic;
    logic [IDX_W-1:0]            r_vic_idx;
    logic [lfu_pkg::DATA_W-1:0]  r_vic_key;
    logic [lfu_pkg::USES_W-1:0]  r_vic_uses;
    logic [lfu_pkg::STAMP_W-1:0] r_vic_stamp;

    // Response register.
    lfu_pkg::t_rsp r_rsp;
    logic          r_rsp_valid;

    // Sequencer outputs.
    logic             req_take;
    logic             issue;
    logic             commit;
    logic [IDX_W-1:0] raddr;

    // Memory connections.
    lfu_pkg::t_entry rdata;
    lfu_pkg::t_entry wdata;
    logic            we;
    logic [IDX_W-1:0] waddr;

    // Commit decisions.
    logic [CMP_W-1:0] cap_sat;
    logic             cap_zero;
    logic             is_put;
    logic             evict;
    logic             do_insert;
    logic             do_touch;
    logic [IDX_W-1:0] insert_idx;
    logic [lfu_pkg::USES_W-1:0]  uses_inc;
    logic [lfu_pkg::STAMP_W-1:0] clock_next;

    // Per-entry evaluation.
    logic entry_valid;
    logic key_match;
    logic vic_better;

    lfu_store #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Configuration writes are always taken.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= lfu_pkg::CAP_RESET;
        end else if (i_cfg.valid) begin
            r_capacity <= i_cfg.payload;
        end
    end

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lfu_pkg::ST_IDLE: begin
                if (i_req.valid) begin
                    n_state = lfu_pkg::ST_SCAN;
                end
            end
            lfu_pkg::ST_SCAN: begin
                if (r_addr == LAST_IDX) begin
                    n_state = lfu_pkg::ST_DRAIN;
                end
            end
            lfu_pkg::ST_DRAIN: begin
                n_state = lfu_pkg::ST_COMMIT;
            end
            lfu_pkg::ST_COMMIT: begin
                if (!r_rsp_valid || o_rsp.ready) begin
                    n_state = lfu_pkg::ST_IDLE;
                end
            end
            default: n_state = lfu_pkg::ST_IDLE;
        endcase
    end

    // Output logic of the sequencer.
    always_comb begin
        req_take = 1'b0;
        issue    = 1'b0;
        commit   = 1'b0;
        raddr    = r_addr;
        unique case (r_state)
            lfu_pkg::ST_IDLE:   req_take = i_req.valid;
            lfu_pkg::ST_SCAN:   issue    = 1'b1;
            lfu_pkg::ST_DRAIN:  issue    = 1'b0;
            lfu_pkg::ST_COMMIT: commit   = !r_rsp_valid || o_rsp.ready;
            default:            issue    = 1'b0;
        endcase
    end

    assign i_req.ready = (r_state == lfu_pkg::ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lfu_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Capture the request.
    always_ff @(posedge i_clk) begin
        if (req_take) begin
            r_req <= i_req.payload;
        end
    end

    // Walk address and read pipeline tracking.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
            r_pend <= 1'b0;
        end else begin
            r_pend <= issue;
            if (req_take) begin
                r_addr <= '0;
            end else if (issue) begin
                r_addr <= r_addr + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_data_idx <= r_addr;
        end
    end

    // Shared compare path over the entry just read.
    assign entry_valid = r_valid[r_data_idx];
    assign key_match   = (rdata.key == r_req.key);
    assign vic_better  = !r_have_vic || (rdata.uses < r_vic_uses) ||
                         ((rdata.uses == r_vic_uses) && (rdata.stamp < r_vic_stamp));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_hit       <= 1'b0;
            r_have_free <= 1'b0;
            r_have_vic  <= 1'b0;
        end else if (req_take) begin
            r_count     <= '0;
            r_hit       <= 1'b0;
            r_have_free <= 1'b0;
            r_have_vic  <= 1'b0;
        end else if (r_pend) begin
            if (entry_valid) begin
                r_count <= r_count + CNT_W'(1);
                if (!r_hit && key_match) begin
                    r_hit <= 1'b1;
                end
                if (vic_better) begin
                    r_have_vic <= 1'b1;
                end
            end else begin
                r_have_free <= 1'b1;
            end
        end
    end

    // Payload captured by the compare path.
    always_ff @(posedge i_clk) begin
        if (r_pend) begin
            if (entry_valid) begin
                if (!r_hit && key_match) begin
                    r_found_idx   <= r_data_idx;
                    r_found_value <= rdata.value;
                    r_found_uses  <= rdata.uses;
                end
                if (vic_better) begin
                    r_vic_idx   <= r_data_idx;
                    r_vic_key   <= rdata.key;
                    r_vic_uses  <= rdata.uses;
                    r_vic_stamp <= rdata.stamp;
                end
            end else if (!r_have_free) begin
                r_free_idx <= r_data_idx;
            end
        end
    end

    // Commit decisions.
    assign cap_sat  = (CMP_W'(r_capacity) > MAX_CAP) ? MAX_CAP : CMP_W'(r_capacity);
    assign cap_zero = (cap_sat == '0);
    assign is_put   = (r_req.mode == lfu_pkg::MODE_PUT);
    assign evict    = is_put && !cap_zero && !r_hit && r_have_vic &&
                      (CMP_W'(r_count) >= cap_sat);
    assign do_insert = is_put && !cap_zero && !r_hit && (evict || r_have_free);
    assign do_touch  = r_hit && (!is_put || !cap_zero);
    assign insert_idx = (evict && !(r_have_free && (r_free_idx < r_vic_idx))) ?
                        r_vic_idx : r_free_idx;
    assign uses_inc   = (r_found_uses == '1) ? r_found_uses
                                             : r_found_uses + lfu_pkg::USES_W'(1);
    assign clock_next = r_clock + lfu_pkg::STAMP_W'(1);

    // Memory write of the touched or inserted entry.
    assign we    = commit && (do_touch || do_insert);
    assign waddr = do_touch ? r_found_idx : insert_idx;

    always_comb begin
        wdata.key   = r_req.key;
        wdata.stamp = clock_next;
        if (do_touch) begin
            wdata.value = is_put ? r_req.value : r_found_value;
            wdata.uses  = uses_inc;
        end else begin
            wdata.value = r_req.value;
            wdata.uses  = lfu_pkg::USES_INIT;
        end
    end

    // Valid bits and access clock.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_clock <= '0;
        end else if (commit) begin
            if (do_touch || do_insert) begin
                r_clock <= clock_next;
            end
            if (evict) begin
                r_valid[r_vic_idx] <= 1'b0;
            end
            if (do_insert) begin
                r_valid[insert_idx] <= 1'b1;
            end
        end
    end

    // Response register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (commit) begin
            r_rsp_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_rsp.hit         <= r_hit;
            r_rsp.read_value  <= is_put ? '0 : (r_hit ? r_found_value : lfu_pkg::MISS_VALUE);
            r_rsp.evicted     <= evict;
            r_rsp.evicted_key <= evict ? r_vic_key : '0;
        end
    end

    assign o_rsp.valid   = r_rsp_valid;
    assign o_rsp.payload = r_rsp;

endmodule

`default_nettype wire

### tb/lfu_cache_policy_tb.sv
// Self-checking testbench for the LFU cache policy block with LRU tie-break.
`timescale 1ns / 100ps

module lfu_cache_policy_tb;

    localparam int unsigned ENTRIES     = lfu_pkg::LFU_ENTRIES;
    localparam int unsigned POOL_SIZE   = 24;
    localparam int unsigned NUM_PHASES  = 10;
    localparam int unsigned PHASE_ITEMS = 60;
    localparam int unsigned LONG_STALL  = 150;
    // About 625 requests, with the long stall on top.
    localparam int unsigned CYCLE_LIMIT = 300000;

    logic i_clk;
    logic i_rst_n;

    lfu_stream_if #(.t_payload(lfu_pkg::t_req)) req_if ();
    lfu_stream_if #(.t_payload(lfu_pkg::t_rsp)) rsp_if ();
    lfu_stream_if #(.t_payload(lfu_pkg::t_cfg)) cfg_if ();

    lfu_cache_policy #(
        .ENTRIES(ENTRIES)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if.sink),
        .o_rsp  (rsp_if.source),
        .i_cfg  (cfg_if.sink)
    );

    // Requests waiting to be offered and responses predicted for accepted requests.
    lfu_pkg::t_req queued_reqs[$];
    lfu_pkg::t_rsp predicted_rsps[$];

    // Shadow copy of the store and the capacity register.
    logic                        slot_live [ENTRIES];
    logic [lfu_pkg::DATA_W-1:0]  slot_key  [ENTRIES];
    logic [lfu_pkg::DATA_W-1:0]  slot_val  [ENTRIES];
    logic [lfu_pkg::USES_W-1:0]  slot_uses [ENTRIES];
    logic [lfu_pkg::STAMP_W-1:0] slot_stamp[ENTRIES];
    logic [lfu_pkg::STAMP_W-1:0] access_clock;
    lfu_pkg::t_cfg               cap_shadow;

    logic signed [lfu_pkg::DATA_W-1:0] key_pool[POOL_SIZE];
    int unsigned                       phase_caps[NUM_PHASES];

    int unsigned   err_count;
    int unsigned   cycle_count;
    logic          req_fire;
    logic          idle_on;
    int unsigned   send_gap;
    int unsigned   hold_left;
    int unsigned   long_stall_req;
    int unsigned   long_stall_seen;
    lfu_pkg::t_rsp rsp_want;

    // Clock generation.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        $display("ERROR at cycle %0d: %s", cycle_count, what);
        err_count++;
    endtask

    // Counts one use of a slot and gives it a fresh stamp.
    function automatic void touch_slot(input int idx);
        if (slot_uses[idx] != '1) begin
            slot_uses[idx] = slot_uses[idx] + 1'b1;
        end
        access_clock = access_clock + 1'b1;
        slot_stamp[idx] = access_clock;
    endfunction

    // Applies one access to the shadow store and returns the expected response.
    function automatic lfu_pkg::t_rsp predict_access(input lfu_pkg::t_req rq);
        lfu_pkg::t_rsp rs;
        int unsigned   lim;
        int unsigned   fill;
        int            hit_slot;
        int            victim;
        int            free_slot;
        bit            found;
        bit            have_victim;
        rs = '0;
        lim = (cap_shadow > ENTRIES) ? ENTRIES : cap_shadow;
        fill = 0;
        found = 1'b0;
        hit_slot = 0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (slot_live[i]) begin
                fill++;
                if (!found && slot_key[i] == rq.key) begin
                    found = 1'b1;
                    hit_slot = i;
                end
            end
        end
        if (rq.mode == lfu_pkg::MODE_GET) begin
            if (found) begin
                rs.read_value = slot_val[hit_slot];
                touch_slot(hit_slot);
            end else begin
                rs.read_value = lfu_pkg::MISS_VALUE;
            end
        end else if (lim != 0) begin
            if (found) begin
                slot_val[hit_slot] = rq.value;
                touch_slot(hit_slot);
            end else begin
                // Full store: drop the least used entry, the oldest among equals.
                if (fill >= lim) begin
                    have_victim = 1'b0;
                    victim = 0;
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (slot_live[i] && (!have_victim || slot_uses[i] < slot_uses[victim] ||
                                (slot_uses[i] == slot_uses[victim] &&
                                 slot_stamp[i] < slot_stamp[victim]))) begin
                            victim = i;
                            have_victim = 1'b1;
                        end
                    end
                    if (have_victim) begin
                        slot_live[victim] = 1'b0;
                        rs.evicted = 1'b1;
                        rs.evicted_key = slot_key[victim];
                    end
                end
                // Insert into the lowest free slot.
                free_slot = ENTRIES;
                for (int i = ENTRIES - 1; i >= 0; i--) begin
                    if (!slot_live[i]) begin
                        free_slot = i;
                    end
                end
                if (free_slot < ENTRIES) begin
                    slot_live[free_slot] = 1'b1;
                    slot_key[free_slot] = rq.key;
                    slot_val[free_slot] = rq.value;
                    slot_uses[free_slot] = lfu_pkg::USES_INIT;
                    access_clock = access_clock + 1'b1;
                    slot_stamp[free_slot] = access_clock;
                end
            end
        end
        rs.hit = found;
        return rs;
    endfunction

    // Cycle counter with the run timeout.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Monitor: tracks every transfer, predicts on requests and checks responses.
    always @(posedge i_clk) begin
        req_fire <= i_rst_n && req_if.valid && req_if.ready;
        if (i_rst_n) begin
            if (cfg_if.valid && cfg_if.ready) begin
                cap_shadow = cfg_if.payload;
            end
            if (rsp_if.valid && rsp_if.ready) begin
                if (predicted_rsps.size() == 0) begin
                    report_mismatch("response transfer with no request outstanding");
                end else begin
                    rsp_want = predicted_rsps[0];
                    predicted_rsps.delete(0);
                    if (rsp_if.payload.hit !== rsp_want.hit) begin
                        report_mismatch($sformatf("hit: got %b, expected %b",
                            rsp_if.payload.hit, rsp_want.hit));
                    end
                    if (rsp_if.payload.read_value !== rsp_want.read_value) begin
                        report_mismatch($sformatf("read_value: got %h, expected %h",
                            rsp_if.payload.read_value, rsp_want.read_value));
                    end
                    if (rsp_if.payload.evicted !== rsp_want.evicted) begin
                        report_mismatch($sformatf("evicted: got %b, expected %b",
                            rsp_if.payload.evicted, rsp_want.evicted));
                    end
                    if (rsp_if.payload.evicted_key !== rsp_want.evicted_key) begin
                        report_mismatch($sformatf("evicted_key: got %h, expected %h",
                            rsp_if.payload.evicted_key, rsp_want.evicted_key));
                    end
                end
            end
            if (req_if.valid && req_if.ready) begin
                predicted_rsps.push_back(predict_access(req_if.payload));
            end
        end
    end

    // Request driver: offers queued requests with random idle bursts between them.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (req_if.valid && !req_fire) begin
            // The offered request has not been taken yet; hold it.
        end else if (send_gap != 0) begin
            req_if.valid <= 1'b0;
            send_gap <= send_gap - 1;
        end else if (queued_reqs.size() != 0) begin
            req_if.payload <= queued_reqs[0];
            queued_reqs.delete(0);
            req_if.valid <= 1'b1;
            if (idle_on && $urandom_range(0, 4) == 0) begin
                send_gap <= $urandom_range(1, 7);
            end
        end else begin
            req_if.valid <= 1'b0;
        end
    end

    // Response receiver: random stall bursts plus the long hold-off on request.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else if (long_stall_req != long_stall_seen) begin
            long_stall_seen <= long_stall_req;
            hold_left <= LONG_STALL;
            rsp_if.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_if.ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            hold_left <= $urandom_range(0, 6);
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= 1'b1;
        end
    end

    task automatic queue_item(input logic mode, input logic signed [lfu_pkg::DATA_W-1:0] key,
                              input logic signed [lfu_pkg::DATA_W-1:0] value);
        lfu_pkg::t_req rq;
        rq.mode = mode;
        rq.key = key;
        rq.value = value;
        queued_reqs.push_back(rq);
    endtask

    // Random accesses over a window of the key pool, with some stray keys mixed in.
    task automatic queue_random(input int unsigned n, input int unsigned span);
        lfu_pkg::t_req rq;
        int unsigned   base;
        base = $urandom_range(0, POOL_SIZE - span);
        repeat (n) begin
            rq.mode = 1'($urandom_range(0, 1));
            rq.value = $urandom;
            if ($urandom_range(0, 9) == 0) begin
                rq.key = $urandom;
            end else begin
                rq.key = key_pool[base + $urandom_range(0, span - 1)];
            end
            queued_reqs.push_back(rq);
        end
    endtask

    // Blocks until every queued request is taken and every response has arrived.
    task automatic wait_drained();
        while (queued_reqs.size() != 0 || req_if.valid || predicted_rsps.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_capacity(input int unsigned cap);
        @(negedge i_clk);
        cfg_if.payload <= lfu_pkg::t_cfg'(cap);
        cfg_if.valid <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!cfg_if.ready);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Stimulus sequence.
    initial begin
        int unsigned span;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.payload = '0;
        rsp_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.payload = '0;
        req_fire = 1'b0;
        idle_on = 1'b1;
        send_gap = 0;
        hold_left = 0;
        long_stall_req = 0;
        long_stall_seen = 0;
        err_count = 0;
        cycle_count = 0;
        access_clock = '0;
        cap_shadow = lfu_pkg::CAP_RESET;
        for (int i = 0; i < ENTRIES; i++) begin
            slot_live[i] = 1'b0;
            slot_key[i] = '0;
            slot_val[i] = '0;
            slot_uses[i] = '0;
            slot_stamp[i] = '0;
        end
        // Key pool: the extremes, a few small keys and random full-width keys.
        key_pool[0] = '0;
        key_pool[1] = -1;
        key_pool[2] = 32'sh7FFFFFFF;
        key_pool[3] = 32'sh80000000;
        for (int i = 4; i < 10; i++) begin
            key_pool[i] = i;
        end
        for (int i = 10; i < POOL_SIZE; i++) begin
            key_pool[i] = $urandom;
        end
        phase_caps = '{16, 31, 1, 3, 0, 8, 17, 2, 5, 16};

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Lookups, inserts and updates at the field extremes, capacity from reset.
        queue_item(lfu_pkg::MODE_GET, 0, 0);
        queue_item(lfu_pkg::MODE_PUT, 32'sh7FFFFFFF, 32'sh80000000);
        queue_item(lfu_pkg::MODE_PUT, 32'sh80000000, 32'sh7FFFFFFF);
        queue_item(lfu_pkg::MODE_PUT, -1, -1);
        queue_item(lfu_pkg::MODE_PUT, 0, 0);
        queue_item(lfu_pkg::MODE_GET, 32'sh7FFFFFFF, 0);
        queue_item(lfu_pkg::MODE_GET, 32'sh80000000, -1);
        queue_item(lfu_pkg::MODE_GET, -1, 0);
        queue_item(lfu_pkg::MODE_PUT, 0, 32'sh5A5A5A5A);
        queue_item(lfu_pkg::MODE_GET, 0, 0);
        queue_item(lfu_pkg::MODE_GET, 12345, 0);

        // Capacity below the current fill: each insert evicts exactly one entry.
        wait_drained();
        write_capacity(2);
        queue_item(lfu_pkg::MODE_PUT, 77, 1);
        queue_item(lfu_pkg::MODE_PUT, 88, 2);

        // Zero capacity: puts change nothing, gets still count uses.
        wait_drained();
        write_capacity(0);
        queue_item(lfu_pkg::MODE_PUT, 99, 3);
        queue_item(lfu_pkg::MODE_PUT, 88, 4);
        queue_item(lfu_pkg::MODE_GET, 88, 0);

        // Equal use counts: the least recently touched entry goes first.
        wait_drained();
        write_capacity(3);
        queue_item(lfu_pkg::MODE_PUT, 1000, 10);
        queue_item(lfu_pkg::MODE_PUT, 1001, 11);
        queue_item(lfu_pkg::MODE_PUT, 1002, 12);
        queue_item(lfu_pkg::MODE_GET, 1001, 0);
        queue_item(lfu_pkg::MODE_PUT, 1003, 13);

        // Capacity above the number of entries saturates.
        wait_drained();
        write_capacity(31);
        for (int i = 0; i < 4; i++) begin
            queue_item(lfu_pkg::MODE_PUT, 2000 + i, $urandom);
        end

        // Random phases, one capacity setting each; the last few run without idling.
        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_drained();
            write_capacity(phase_caps[p]);
            idle_on = (p < NUM_PHASES - 3);
            span = ((phase_caps[p] > ENTRIES) ? ENTRIES : phase_caps[p]) + 1 +
                   $urandom_range(0, 4);
            queue_random(PHASE_ITEMS, span);
            // Hold the receiver off while the sender keeps offering requests.
            if (p == 1) begin
                long_stall_req++;
            end
        end

        wait_drained();
        repeat (ENTRIES + 8) @(posedge i_clk);
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### lfu_cache_policy.f
src/lfu_pkg.sv
src/lfu_stream_if.sv
src/lfu_store.sv
src/lfu_cache_policy.sv
tb/lfu_cache_policy_tb.sv
